// ----- design/spf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spf_pkg;

    localparam int unsigned PKT_LEN  = 20;
    localparam int unsigned LAST_POS = PKT_LEN - 1;
    localparam int unsigned POS_W    = $clog2(PKT_LEN);
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned PADDR_W  = 5;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LAST_POS);

    localparam logic [7:0] HDR_ID  = 8'd19;
    localparam logic [7:0] LEN_ID  = 8'(PKT_LEN - 3);
    localparam logic [7:0] IR_QUIT = 8'd137;

    localparam logic [2:0] REG_THR_L  = 3'd0;
    localparam logic [2:0] REG_THR_FL = 3'd1;
    localparam logic [2:0] REG_THR_FR = 3'd2;
    localparam logic [2:0] REG_THR_R  = 3'd3;
    localparam logic [2:0] REG_POL    = 3'd4;

    localparam logic [1:0] ACT_FWD  = 2'd0;
    localparam logic [1:0] ACT_BACK = 2'd3;

    typedef struct packed {
        logic        chk;
        logic [7:0]  val;
    } t_id_chk;

    typedef struct packed {
        logic        ok;
        logic [15:0] left;
        logic [15:0] fleft;
        logic [15:0] fright;
        logic [15:0] right;
        logic [15:0] distance;
        logic [7:0]  ir;
    } t_scan_res;

    typedef struct packed {
        logic        status;
        logic [15:0] left;
        logic [15:0] fleft;
        logic [15:0] fright;
        logic [15:0] right;
        logic [3:0]  cliff;
        logic [15:0] distance;
        logic [7:0]  ir;
        logic        quit;
        logic        stop;
        logic [2:0]  led;
        logic [15:0] count;
    } t_result;

    function automatic t_id_chk id_expect(input logic [POS_W-1:0] pos);
        t_id_chk r;
        r.chk = 1'b1;
        case (pos)
            5'd0:    r.val = HDR_ID;
            5'd1:    r.val = LEN_ID;
            5'd2:    r.val = 8'd28;
            5'd5:    r.val = 8'd29;
            5'd8:    r.val = 8'd30;
            5'd11:   r.val = 8'd31;
            5'd14:   r.val = 8'd19;
            5'd17:   r.val = 8'd17;
            default: begin
                r.chk = 1'b0;
                r.val = 8'd0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- design/sensor_packet_framer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                  | payload
// ----------+----------------------------+-------------------------------------
// rx in     | i_in_valid / o_in_stall    | i_rx_byte, i_current_action
// result    | o_out_valid / i_out_stall  | o_status, cliff raws, o_cliff_bits,
//           |                            | o_wheel_distance, o_ir_code, flags
// config    | APB psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
// A byte that does not complete the window is written to the window RAM without
// stalling the input. The completing byte starts a sweep of the window RAM, one
// read per cycle, and the input is stalled until the result is loaded.
// A result waiting in the output register does not block new bytes; the next
// result waits for it. Synchronous active-low reset empties the window.

module sensor_packet_framer
    import spf_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic [1:0]         i_current_action,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_status,
    output logic [15:0]             o_cliff_left_raw,
    output logic [15:0]             o_cliff_front_left_raw,
    output logic [15:0]             o_cliff_front_right_raw,
    output logic [15:0]             o_cliff_right_raw,
    output logic [3:0]              o_cliff_bits,
    output logic signed [15:0]      o_wheel_distance,
    output logic [7:0]              o_ir_code,
    output logic                    o_quit_request,
    output logic                    o_stop_wheels,
    output logic [2:0]              o_led_bits,
    output logic [15:0]             o_packet_count,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [POS_W-1:0]  r_base;
    logic [POS_W-1:0]  r_fill;
    logic [15:0]       r_count;
    logic [1:0]        r_action;
    logic [15:0]       r_thr_l, r_thr_fl, r_thr_fr, r_thr_r;
    logic              r_pol;
    logic              r_out_valid;
    t_result           r_out;

    logic              in_xfer, out_free, load, start, cfg_wr, scan_done;
    logic [2:0]        cfg_idx;
    logic [POS_W-1:0]  wr_addr, rd_addr, rd_idx;
    logic [BYTE_W-1:0] rd_data;
    t_scan_res         scan_res;
    t_result           dec_res;

    function automatic logic [POS_W-1:0] wrap_add(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (POS_W+1)'(PKT_LEN)) begin
            s = s - (POS_W+1)'(PKT_LEN);
        end
        return s[POS_W-1:0];
    endfunction

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign start      = in_xfer && (r_fill == POS_LAST);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load       = out_free && (((r_state == S_SCAN) && scan_done) ||
                                     (r_state == S_HOLD));
    assign wr_addr    = wrap_add(r_base, r_fill);
    assign rd_addr    = wrap_add(r_base, rd_idx);

    spf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (PKT_LEN)
    ) u_win (
        .i_clk   (i_clk),
        .i_we    (in_xfer),
        .i_waddr (wr_addr),
        .i_wdata (i_rx_byte),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    spf_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_rd_data (rd_data),
        .o_rd_idx  (rd_idx),
        .o_done    (scan_done),
        .o_res     (scan_res)
    );

    spf_decode u_dec (
        .i_scan   (scan_res),
        .i_thr_l  (r_thr_l),
        .i_thr_fl (r_thr_fl),
        .i_thr_fr (r_thr_fr),
        .i_thr_r  (r_thr_r),
        .i_pol    (r_pol),
        .i_action (r_action),
        .i_count  (r_count),
        .o_res    (dec_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start) n_state = S_SCAN;
            S_SCAN:  if (scan_done) n_state = load ? S_IDLE : S_HOLD;
            S_HOLD:  if (load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= '0;
            r_fill      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer && !start) begin
                r_fill <= r_fill + 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
                if (scan_res.ok) begin
                    r_fill  <= '0;
                    r_count <= r_count + 1'b1;
                end else begin
                    r_fill <= POS_LAST;
                    r_base <= wrap_add(r_base, POS_W'(1));
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_action <= i_current_action;
        end
        if (load) begin
            r_out <= dec_res;
        end
    end

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_l  <= '0;
            r_thr_fl <= '0;
            r_thr_fr <= '0;
            r_thr_r  <= '0;
            r_pol    <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_THR_L:  r_thr_l  <= pwdata[15:0];
                REG_THR_FL: r_thr_fl <= pwdata[15:0];
                REG_THR_FR: r_thr_fr <= pwdata[15:0];
                REG_THR_R:  r_thr_r  <= pwdata[15:0];
                REG_POL:    r_pol    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_THR_L:  prdata = {16'd0, r_thr_l};
            REG_THR_FL: prdata = {16'd0, r_thr_fl};
            REG_THR_FR: prdata = {16'd0, r_thr_fr};
            REG_THR_R:  prdata = {16'd0, r_thr_r};
            REG_POL:    prdata = {31'd0, r_pol};
            default:    prdata = '0;
        endcase
    end

    assign o_out_valid             = r_out_valid;
    assign o_status                = r_out.status;
    assign o_cliff_left_raw        = r_out.left;
    assign o_cliff_front_left_raw  = r_out.fleft;
    assign o_cliff_front_right_raw = r_out.fright;
    assign o_cliff_right_raw       = r_out.right;
    assign o_cliff_bits            = r_out.cliff;
    assign o_wheel_distance        = $signed(r_out.distance);
    assign o_ir_code               = r_out.ir;
    assign o_quit_request          = r_out.quit;
    assign o_stop_wheels           = r_out.stop;
    assign o_led_bits              = r_out.led;
    assign o_packet_count          = r_out.count;

endmodule

`default_nettype wire

// ----- design/spf_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 20,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- design/spf_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spf_scan
    import spf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [BYTE_W-1:0] i_rd_data,
    output logic      [POS_W-1:0]  o_rd_idx,
    output logic                   o_done,
    output t_scan_res              o_res
);

    logic              r_busy;
    logic [POS_W-1:0]  r_idx;
    logic              r_dv;
    logic [POS_W-1:0]  r_dpos;
    logic              r_done;
    logic [7:0]        r_sum;
    logic              r_id_ok;
    logic [15:0]       r_left, r_fleft, r_fright, r_right, r_dist;
    logic [7:0]        r_ir;
    t_id_chk           exp_id;

    assign exp_id   = id_expect(r_dpos);
    assign o_rd_idx = r_idx;
    assign o_done   = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_dv   <= 1'b0;
            r_dpos <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_dv && (r_dpos == POS_LAST);
            r_dv   <= r_busy;
            r_dpos <= r_idx;
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (r_busy) begin
                if (r_idx == POS_LAST) begin
                    r_busy <= 1'b0;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sum   <= '0;
            r_id_ok <= 1'b1;
        end else if (r_dv) begin
            r_sum <= r_sum + i_rd_data;
            if (exp_id.chk && (i_rd_data != exp_id.val)) begin
                r_id_ok <= 1'b0;
            end
            case (r_dpos)
                5'd3:    r_left[15:8]   <= i_rd_data;
                5'd4:    r_left[7:0]    <= i_rd_data;
                5'd6:    r_fleft[15:8]  <= i_rd_data;
                5'd7:    r_fleft[7:0]   <= i_rd_data;
                5'd9:    r_fright[15:8] <= i_rd_data;
                5'd10:   r_fright[7:0]  <= i_rd_data;
                5'd12:   r_right[15:8]  <= i_rd_data;
                5'd13:   r_right[7:0]   <= i_rd_data;
                5'd15:   r_dist[15:8]   <= i_rd_data;
                5'd16:   r_dist[7:0]    <= i_rd_data;
                5'd18:   r_ir           <= i_rd_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_res.ok       = r_id_ok && (r_sum == 8'd0);
        o_res.left     = r_left;
        o_res.fleft    = r_fleft;
        o_res.fright   = r_fright;
        o_res.right    = r_right;
        o_res.distance = r_dist;
        o_res.ir       = r_ir;
    end

endmodule

`default_nettype wire

// ----- design/spf_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spf_decode
    import spf_pkg::*;
(
    input  t_scan_res         i_scan,
    input  wire logic [15:0]  i_thr_l,
    input  wire logic [15:0]  i_thr_fl,
    input  wire logic [15:0]  i_thr_fr,
    input  wire logic [15:0]  i_thr_r,
    input  wire logic         i_pol,
    input  wire logic [1:0]   i_action,
    input  wire logic [15:0]  i_count,
    output t_result           o_res
);

    logic bl, bfl, bfr, br, front;

    assign bl    = ~((i_scan.left   > i_thr_l)  ^ i_pol);
    assign bfl   = ~((i_scan.fleft  > i_thr_fl) ^ i_pol);
    assign bfr   = ~((i_scan.fright > i_thr_fr) ^ i_pol);
    assign br    = ~((i_scan.right  > i_thr_r)  ^ i_pol);
    assign front = bfl | bfr;

    always_comb begin
        o_res        = '0;
        o_res.status = 1'b1;
        if (i_scan.ok) begin
            o_res.status   = 1'b0;
            o_res.left     = i_scan.left;
            o_res.fleft    = i_scan.fleft;
            o_res.fright   = i_scan.fright;
            o_res.right    = i_scan.right;
            o_res.cliff    = {bl, bfl, bfr, br};
            o_res.distance = i_scan.distance;
            o_res.ir       = i_scan.ir;
            o_res.quit     = (i_scan.ir == IR_QUIT);
            o_res.stop     = ((i_action == ACT_FWD) && front) ||
                             ((i_action == ACT_BACK) && (bl | br));
            o_res.led      = {bl, front, br};
            o_res.count    = i_count;
        end
    end

endmodule

`default_nettype wire

// ----- design/spf_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spf_checker
    import spf_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic [7:0]         i_rx_byte,
    input wire logic [1:0]         i_current_action,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic               o_status,
    input wire logic [15:0]        o_cliff_left_raw,
    input wire logic [15:0]        o_cliff_front_left_raw,
    input wire logic [15:0]        o_cliff_front_right_raw,
    input wire logic [15:0]        o_cliff_right_raw,
    input wire logic [3:0]         o_cliff_bits,
    input wire logic signed [15:0] o_wheel_distance,
    input wire logic [7:0]         o_ir_code,
    input wire logic               o_quit_request,
    input wire logic               o_stop_wheels,
    input wire logic [2:0]         o_led_bits,
    input wire logic [15:0]        o_packet_count,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic [PADDR_W-1:0] paddr,
    input wire logic [31:0]        pwdata,
    input wire logic [31:0]        prdata,
    input wire logic               pready
);

    // misaligned window carries nothing but the status flag
    a_shift_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |->
            (o_cliff_left_raw == 16'd0) && (o_cliff_right_raw == 16'd0) &&
            (o_cliff_front_left_raw == 16'd0) && (o_cliff_front_right_raw == 16'd0) &&
            (o_cliff_bits == 4'd0) && (o_wheel_distance == 16'sd0) &&
            (o_ir_code == 8'd0) && !o_quit_request && !o_stop_wheels &&
            (o_led_bits == 3'd0) && (o_packet_count == 16'd0))
        else $error("shifted-window transfer with nonzero payload");

    a_quit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_quit_request == (o_ir_code == IR_QUIT)))
        else $error("quit flag does not match ir code");

    a_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_led_bits[2] == o_cliff_bits[3]) &&
                        (o_led_bits[1] == (o_cliff_bits[2] | o_cliff_bits[1])) &&
                        (o_led_bits[0] == o_cliff_bits[0]))
        else $error("led bits disagree with cliff bits");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            o_out_valid && $stable(o_status) && $stable(o_packet_count) &&
            $stable(o_cliff_bits) && $stable(o_wheel_distance))
        else $error("stalled result changed");

endmodule

bind sensor_packet_framer spf_checker u_spf_checker (.*);

`default_nettype wire
